/* rtl/asymmetric_exp_waveshaper_defines.svh */
// Assertion macros used by the waveshaper top module.
`ifndef ASYMMETRIC_EXP_WAVESHAPER_DEFINES_SVH
`define ASYMMETRIC_EXP_WAVESHAPER_DEFINES_SVH

`ifndef SYNTHESIS
`define AEW_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("waveshaper check failed");
`define AEW_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("waveshaper check failed");
`else
`define AEW_ASSERT_IMP(name, ante, cons)
`define AEW_ASSERT_NXT(name, ante, cons)
`endif

`endif

/* rtl/aew_pkg.sv */
`default_nettype none
package aew_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 4;
    localparam int PROD_W      = SAMPLE_BITS + 32;
    localparam int PROD_FB     = FRAC_BITS + 16;
    localparam int BASE_FB     = 28;
    localparam int LOG2_LOG2E  = 554452;
    localparam int OUT_SHIFT   = 48 - FRAC_BITS;
    localparam int ALPHA_RSH   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int ALPHA_LSH   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int TAB_LEN     = 33;
    localparam int LOG_STEPS   = 20;
    localparam int LOG_LAT     = LOG_STEPS + 2;
    localparam int POW_STEPS   = 32;
    localparam int POW_LAT     = POW_STEPS;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_PREGAIN = 3'd0,
        REG_POS_SHAPE   = 3'd1,
        REG_NEG_PREGAIN = 3'd2,
        REG_NEG_SHAPE   = 3'd3,
        REG_POSTGAIN    = 3'd4,
        REG_SYMMETRIC   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic              neg;
        logic              bend;
        logic              zero;
        logic              full;
        logic [15:0]       e;
        logic signed [6:0] s;
        logic [5:0]        zi;
        logic              zf0;
    } t_ctl;

    typedef logic [TAB_LEN-1:0][63:0] t_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_tab build_tab();
        t_tab t;
        t[0] = 64'd2 << 31;
        for (int i = 1; i < TAB_LEN; i++) begin
            t[i] = isqrt64(t[i-1] << 31);
        end
        return t;
    endfunction

    localparam t_tab TAB = build_tab();

endpackage
`default_nettype wire

/* rtl/aew_if.sv */
`default_nettype none
interface aew_in_if import aew_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_in;
    logic                   buffer_end_in;
    modport source (output valid, output sample_in, output buffer_end_in, input ready);
    modport sink (input valid, input sample_in, input buffer_end_in, output ready);
endinterface

interface aew_out_if import aew_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   buffer_end_out;
    modport source (output valid, output sample_out, output buffer_end_out, input ready);
    modport sink (input valid, input sample_out, input buffer_end_out, output ready);
endinterface

interface aew_cfg_if import aew_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/aew_log2.sv */
`default_nettype none
module aew_log2 import aew_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_en,
    input  wire         i_valid,
    input  wire  [63:0] i_val,
    output logic        o_valid,
    output logic [5:0]  o_exp,
    output logic [19:0] o_frac
);

    logic        r_a_valid;
    logic [63:0] r_a_v;
    logic [5:0]  r_a_p;
    logic        r_b_valid;
    logic [31:0] r_b_mz;
    logic [5:0]  r_b_p;
    logic [5:0]  n_a_p;
    logic [63:0] n_b_sh;

    logic        r_vld [LOG_STEPS];
    logic [31:0] r_mz  [LOG_STEPS];
    logic [19:0] r_fr  [LOG_STEPS];
    logic [5:0]  r_p   [LOG_STEPS];

    always_comb begin
        n_a_p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (i_val[i]) begin
                n_a_p = 6'(i);
            end
        end
    end

    always_comb begin
        if (r_a_p >= 6'd31) begin
            n_b_sh = r_a_v >> (r_a_p - 6'd31);
        end else begin
            n_b_sh = r_a_v << (6'd31 - r_a_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
        if (i_en) begin
            r_a_v  <= i_val;
            r_a_p  <= n_a_p;
            r_b_mz <= n_b_sh[31:0];
            r_b_p  <= r_a_p;
        end
    end

    for (genvar j = 0; j < LOG_STEPS; j++) begin : g_sq
        logic [31:0] w_mz_in;
        logic [19:0] w_fr_in;
        logic [5:0]  w_p_in;
        logic        w_vld_in;
        logic [63:0] w_sq;
        logic [32:0] w_t;
        if (j == 0) begin : g_first
            assign w_mz_in  = r_b_mz;
            assign w_fr_in  = 20'd0;
            assign w_p_in   = r_b_p;
            assign w_vld_in = r_b_valid;
        end else begin : g_next
            assign w_mz_in  = r_mz[j-1];
            assign w_fr_in  = r_fr[j-1];
            assign w_p_in   = r_p[j-1];
            assign w_vld_in = r_vld[j-1];
        end
        assign w_sq = w_mz_in * w_mz_in;
        assign w_t  = w_sq[63:31];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld_in;
            end
            if (i_en) begin
                r_p[j] <= w_p_in;
                if (w_t[32]) begin
                    r_mz[j] <= w_t[32:1];
                    r_fr[j] <= w_fr_in | (20'd1 << (LOG_STEPS - 1 - j));
                end else begin
                    r_mz[j] <= w_t[31:0];
                    r_fr[j] <= w_fr_in;
                end
            end
        end
    end

    assign o_valid = r_vld[LOG_STEPS-1];
    assign o_exp   = r_p[LOG_STEPS-1];
    assign o_frac  = r_fr[LOG_STEPS-1];

endmodule
`default_nettype wire

/* rtl/aew_pow2.sv */
`default_nettype none
module aew_pow2 import aew_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_en,
    input  wire         i_valid,
    input  wire  [31:0] i_f,
    output logic        o_valid,
    output logic [31:0] o_mant
);

    logic        r_vld  [POW_STEPS];
    logic [31:0] r_f    [POW_STEPS];
    logic [31:0] r_mant [POW_STEPS];

    for (genvar j = 0; j < POW_STEPS; j++) begin : g_mul
        logic [31:0] w_mant_in;
        logic [31:0] w_f_in;
        logic        w_vld_in;
        logic [63:0] w_prod;
        if (j == 0) begin : g_first
            assign w_mant_in = 32'h8000_0000;
            assign w_f_in    = i_f;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            assign w_mant_in = r_mant[j-1];
            assign w_f_in    = r_f[j-1];
            assign w_vld_in  = r_vld[j-1];
        end
        assign w_prod = w_mant_in * TAB[j+1][31:0];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld_in;
            end
            if (i_en) begin
                r_f[j] <= w_f_in;
                if (w_f_in[POW_STEPS-1-j]) begin
                    r_mant[j] <= w_prod[62:31];
                end else begin
                    r_mant[j] <= w_mant_in;
                end
            end
        end
    end

    assign o_valid = r_vld[POW_STEPS-1];
    assign o_mant  = r_mant[POW_STEPS-1];

endmodule
`default_nettype wire

/* rtl/asymmetric_exp_waveshaper.sv */
// Channel   Direction  Payload
// i_in      sink       sample_in (signed Q4.20), buffer_end_in
// o_out     source     sample_out (signed Q4.20), buffer_end_out
// i_cfg     sink       index (3 bits), data (48 bits); ready is always high
//
// One sample per cycle enters while the output is not stalled. The pipeline holds one
// 22-stage log2 pass (both logarithms run in parallel) and the two 32-stage exp2
// units, plus nine single stages.
// Reset is synchronous and clears all valid bits and restores register defaults.
// An output stall freezes the whole pipeline; a one-entry skid register takes
// one more input transfer while the pipeline is frozen.
`default_nettype none
`include "asymmetric_exp_waveshaper_defines.svh"
module asymmetric_exp_waveshaper import aew_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    aew_in_if.sink      i_in,
    aew_out_if.source   o_out,
    aew_cfg_if.sink     i_cfg
);

    localparam logic [SAMPLE_BITS-1:0] ONE = SAMPLE_BITS'(1) << FRAC_BITS;
    localparam logic [57:0] RND = 58'd1 << (OUT_SHIFT - 1);
    localparam logic [57:0] LIM_POS = (58'd1 << (SAMPLE_BITS - 1)) - 58'd1;
    localparam logic [57:0] LIM_NEG = 58'd1 << (SAMPLE_BITS - 1);

    logic [31:0] r_pos_pregain;
    logic [47:0] r_pos_shape;
    logic [31:0] r_neg_pregain;
    logic [47:0] r_neg_shape;
    logic [23:0] r_postgain;
    logic        r_symmetric;

    logic                   w_en;
    logic                   r_skid_valid;
    logic [SAMPLE_BITS-1:0] r_skid_sample;
    logic                   r_skid_bend;
    logic                   w_src_valid;
    logic [SAMPLE_BITS-1:0] w_src_sample;
    logic                   w_src_bend;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_pregain <= 32'd655360;
            r_pos_shape   <= 48'h1000_1000_1000;
            r_neg_pregain <= 32'd655360;
            r_neg_shape   <= 48'h1000_1000_1000;
            r_postgain    <= 24'd65536;
            r_symmetric   <= 1'b1;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_POS_PREGAIN: r_pos_pregain <= i_cfg.data[31:0];
                REG_POS_SHAPE:   r_pos_shape   <= i_cfg.data;
                REG_NEG_PREGAIN: r_neg_pregain <= i_cfg.data[31:0];
                REG_NEG_SHAPE:   r_neg_shape   <= i_cfg.data;
                REG_POSTGAIN:    r_postgain    <= i_cfg.data[23:0];
                REG_SYMMETRIC:   r_symmetric   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign w_en        = !o_out.valid || o_out.ready;
    assign i_in.ready  = !r_skid_valid;
    assign w_src_valid = r_skid_valid || i_in.valid;
    assign w_src_sample = r_skid_valid ? r_skid_sample : i_in.sample_in;
    assign w_src_bend   = r_skid_valid ? r_skid_bend : i_in.buffer_end_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
        end else if (i_in.valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
        if (!w_en && !r_skid_valid) begin
            r_skid_sample <= i_in.sample_in;
            r_skid_bend   <= i_in.buffer_end_in;
        end
    end

    // Stage 1: sign, magnitude and parameter set.
    logic                   r1_valid;
    logic [SAMPLE_BITS-1:0] r1_m;
    logic                   r1_neg;
    logic                   r1_bend;
    logic [31:0]            r1_gain;
    logic [47:0]            r1_shape;
    logic                   n1_neg;
    logic                   n1_usepos;

    assign n1_neg    = w_src_sample[SAMPLE_BITS-1];
    assign n1_usepos = r_symmetric || !n1_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= w_src_valid;
        end
        if (w_en) begin
            r1_m     <= n1_neg ? SAMPLE_BITS'(-w_src_sample) : w_src_sample;
            r1_neg   <= n1_neg;
            r1_bend  <= w_src_bend;
            r1_gain  <= n1_usepos ? r_pos_pregain : r_neg_pregain;
            r1_shape <= n1_usepos ? r_pos_shape : r_neg_shape;
        end
    end

    // Stage 2: products for the numerator and the interpolated base.
    logic                   r2_valid;
    t_ctl                   r2_ctl;
    logic [PROD_W-1:0]      r2_prod;
    logic [32:0]            r2_pa;
    logic [32:0]            r2_pb;
    logic [SAMPLE_BITS-1:0] n2_mc;
    logic [16:0]            n2_alpha;
    logic [32:0]            n2_mc_w;
    t_ctl                   n2_ctl;

    assign n2_mc    = (r1_m < ONE) ? r1_m : ONE;
    assign n2_mc_w  = (33'(n2_mc) >> ALPHA_RSH) << ALPHA_LSH;
    assign n2_alpha = n2_mc_w[16:0];

    always_comb begin
        n2_ctl      = '0;
        n2_ctl.neg  = r1_neg;
        n2_ctl.bend = r1_bend;
        n2_ctl.zero = (r1_m == '0) || (r1_gain == 32'd0);
        n2_ctl.e    = r1_shape[47:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
        if (w_en) begin
            r2_ctl  <= n2_ctl;
            r2_prod <= PROD_W'(r1_m) * PROD_W'(r1_gain);
            r2_pa   <= 33'(r1_shape[15:0]) * 33'(17'd65536 - n2_alpha);
            r2_pb   <= 33'(r1_shape[31:16]) * 33'(n2_alpha);
        end
    end

    // Stage 3: base sum and the zero-denominator flag.
    logic              r3_valid;
    t_ctl              r3_ctl;
    logic [32:0]       r3_base;
    logic [PROD_W-1:0] r3_prod;
    logic [32:0]       n3_base;
    t_ctl              n3_ctl;

    assign n3_base = r2_pa + r2_pb;

    always_comb begin
        n3_ctl      = r2_ctl;
        n3_ctl.full = (n3_base == 33'd0) && (r2_ctl.e != 16'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
        if (w_en) begin
            r3_ctl  <= n3_ctl;
            r3_base <= n3_base;
            r3_prod <= r2_prod;
        end
    end

    // Both logarithms in parallel.
    logic        w_lb_valid;
    logic [5:0]  w_lb_exp;
    logic [19:0] w_lb_frac;
    logic        w_lp_valid;
    logic [5:0]  w_lp_exp;
    logic [19:0] w_lp_frac;
    t_ctl        r_da [LOG_LAT];

    aew_log2 u_log_base (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_valid),
        .i_val   (64'(r3_base)),
        .o_valid (w_lb_valid),
        .o_exp   (w_lb_exp),
        .o_frac  (w_lb_frac)
    );

    aew_log2 u_log_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_valid),
        .i_val   (64'(r3_prod)),
        .o_valid (w_lp_valid),
        .o_exp   (w_lp_exp),
        .o_frac  (w_lp_frac)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_da[0] <= r3_ctl;
            for (int i = 1; i < LOG_LAT; i++) begin
                r_da[i] <= r_da[i-1];
            end
        end
    end

    // Stage 4: signed logs and exponent product.
    logic               r4_valid;
    t_ctl               r4_ctl;
    logic signed [27:0] r4_lp;
    logic signed [44:0] r4_ldp;
    logic signed [7:0]  n4_lb_int;
    logic signed [7:0]  n4_lp_int;
    logic signed [27:0] n4_lb;

    assign n4_lb_int = $signed({2'b00, w_lb_exp}) - 8'(BASE_FB);
    assign n4_lp_int = $signed({2'b00, w_lp_exp}) - 8'(PROD_FB);
    assign n4_lb     = $signed({n4_lb_int, w_lb_frac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= w_lb_valid && w_lp_valid;
        end
        if (w_en) begin
            r4_ctl <= r_da[LOG_LAT-1];
            r4_lp  <= $signed({n4_lp_int, w_lp_frac});
            r4_ldp <= 45'(n4_lb) * 45'($signed({1'b0, r_da[LOG_LAT-1].e}));
        end
    end

    // Stage 5: exponent argument t in Q.20.
    logic               r5_valid;
    t_ctl               r5_ctl;
    logic signed [35:0] r5_t;
    logic signed [35:0] n5_t;
    logic signed [15:0] n5_s;
    t_ctl               n5_ctl;
    t_ctl               n5_next_ctl;
    t_ctl               r_db [POW_LAT];
    logic               w_p1_valid;
    logic [31:0]        w_p1_mant;

    assign n5_t = 36'(r4_lp) - 36'(r4_ldp >>> 12) + 36'(LOG2_LOG2E);

    always_comb begin
        n5_next_ctl      = r4_ctl;
        n5_next_ctl.full = r4_ctl.full || (n5_t >= 36'sd6291456);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (w_en) begin
            r5_valid <= r4_valid;
        end
        if (w_en) begin
            r5_ctl <= n5_next_ctl;
            r5_t   <= n5_t;
        end
    end

    always_comb begin
        n5_s   = 16'(r5_t >>> 20) + 16'sd1;
        n5_ctl = r5_ctl;
        if (n5_s < -16'sd40) begin
            n5_ctl.s = -7'sd40;
        end else if (n5_s > 16'sd6) begin
            n5_ctl.s = 7'sd6;
        end else begin
            n5_ctl.s = 7'(n5_s);
        end
    end

    aew_pow2 u_pow_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_valid),
        .i_f     ({r5_t[19:0], 12'd0}),
        .o_valid (w_p1_valid),
        .o_mant  (w_p1_mant)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_db[0] <= n5_ctl;
            for (int i = 1; i < POW_LAT; i++) begin
                r_db[i] <= r_db[i-1];
            end
        end
    end

    // Stage 6: z = 2^t split into integer and fraction.
    logic        r6_valid;
    t_ctl        r6_ctl;
    logic [31:0] r6_fz;
    logic [37:0] n6_z;
    t_ctl        n6_ctl;
    t_ctl        r_dc [POW_LAT];
    logic        w_p2_valid;
    logic [31:0] w_p2_mant;

    always_comb begin
        n6_ctl = r_db[POW_LAT-1];
        if (n6_ctl.s >= 7'sd0) begin
            n6_z = 38'(w_p1_mant) << n6_ctl.s[2:0];
        end else begin
            n6_z = 38'(w_p1_mant) >> 6'(-n6_ctl.s);
        end
        n6_ctl.zi  = n6_z[37:32];
        n6_ctl.zf0 = (n6_z[31:0] == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (w_en) begin
            r6_valid <= w_p1_valid;
        end
        if (w_en) begin
            r6_ctl <= n6_ctl;
            r6_fz  <= 32'd0 - n6_z[31:0];
        end
    end

    aew_pow2 u_pow_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_valid),
        .i_f     (r6_fz),
        .o_valid (w_p2_valid),
        .o_mant  (w_p2_mant)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dc[0] <= r6_ctl;
            for (int i = 1; i < POW_LAT; i++) begin
                r_dc[i] <= r_dc[i-1];
            end
        end
    end

    // Stage 7: y1 = 1 - 2^-z in Q.32.
    logic        r7_valid;
    t_ctl        r7_ctl;
    logic [32:0] r7_y1;
    logic [32:0] n7_w;
    t_ctl        n7_ctl;

    assign n7_ctl = r_dc[POW_LAT-1];
    assign n7_w   = n7_ctl.zf0 ? (33'h1_0000_0000 >> n7_ctl.zi)
                               : (33'(w_p2_mant) >> n7_ctl.zi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (w_en) begin
            r7_valid <= w_p2_valid;
        end
        if (w_en) begin
            r7_ctl <= n7_ctl;
            r7_y1  <= n7_ctl.full ? 33'h1_0000_0000 : 33'h1_0000_0000 - n7_w;
        end
    end

    // Stage 8: output gain.
    logic        r8_valid;
    t_ctl        r8_ctl;
    logic [56:0] r8_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else if (w_en) begin
            r8_valid <= r7_valid;
        end
        if (w_en) begin
            r8_ctl <= r7_ctl;
            r8_p   <= r7_y1 * r_postgain;
        end
    end

    // Stage 9: rounding, saturation and sign.
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic                   r_out_bend;
    logic [57:0]            n9_mag;
    logic [57:0]            n9_sat;
    logic [SAMPLE_BITS-1:0] n9_res;

    always_comb begin
        n9_mag = r8_ctl.zero ? 58'd0 : ((58'(r8_p) + RND) >> OUT_SHIFT);
        if (r8_ctl.neg) begin
            n9_sat = (n9_mag > LIM_NEG) ? LIM_NEG : n9_mag;
            n9_res = SAMPLE_BITS'(58'd0 - n9_sat);
        end else begin
            n9_sat = (n9_mag > LIM_POS) ? LIM_POS : n9_mag;
            n9_res = SAMPLE_BITS'(n9_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r8_valid;
        end
        if (w_en) begin
            r_out_sample <= n9_res;
            r_out_bend   <= r8_ctl.bend;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sample_out     = r_out_sample;
    assign o_out.buffer_end_out = r_out_bend;

    `AEW_ASSERT_NXT(a_stall_freezes, !w_en, $stable({r1_valid, r2_valid, r3_valid, r_out_valid}))
    `AEW_ASSERT_IMP(a_skid_only_on_stall, $rose(r_skid_valid), $past(!w_en))
    `AEW_ASSERT_NXT(a_skid_kept, r_skid_valid && !w_en, r_skid_valid)
    `AEW_ASSERT_NXT(a_direct_entry, w_en && !r_skid_valid && i_in.valid, r1_valid)

endmodule
`default_nettype wire
